[rtl/bed_pkg.sv]
`timescale 1ns / 1ps
// Package for the backslash escape decoder: decode mode type, result type,
// character constants and character class helpers. No dependencies.

package bed_pkg;

    // decode modes, one-hot
    typedef enum logic [3:0] {
        MODE_TEXT = 4'b0001,
        MODE_ESC  = 4'b0010,
        MODE_HEX1 = 4'b0100,
        MODE_HEX2 = 4'b1000
    } t_mode;

    // one decoded output beat
    typedef struct packed {
        logic [7:0] data;
        logic       str_end;
    } t_result;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_SQ    = 8'h27;
    localparam logic [7:0] CHAR_DQ    = 8'h22;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF_HX = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;

    // decimal digit test
    function automatic logic is_dec(input logic [7:0] c);
        return (c inside {[CHAR_0:CHAR_9]});
    endfunction

    // hex digit test, either case
    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[CHAR_0:CHAR_9], [CHAR_LA:CHAR_LF_HX], [CHAR_UA:CHAR_UF]});
    endfunction

    // nibble value of a hex digit
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[CHAR_0:CHAR_9]}) begin
            v = c - CHAR_0;
        end else if (c inside {[CHAR_LA:CHAR_LF_HX]}) begin
            v = c - CHAR_LA + 8'd10;
        end else begin
            v = c - CHAR_UA + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

[rtl/backslash_escape_decoder.sv]
`timescale 1ns / 1ps
// The first result of an accepted input beat appears in the output register in the cycle
// after that beat. One input beat per cycle while the output is not stalled; a beat that
// yields two results stalls the input while the second result drains from the pending slot.
// Reset (synchronous, active low): normal text mode, held hex digit zero,
// output and pending slots empty.
// Depends on bed_pkg.

module backslash_escape_decoder
    import bed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_decoded_byte,
    output logic       o_string_end,
    output logic       o_last_of_run
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_held, n_held;

    t_result    r_out, r_pend;
    logic       r_out_valid, r_pend_valid, r_out_last;

    // decode results for the incoming beat
    t_result    res0, res1;
    logic [1:0] res_cnt;

    logic       out_free;
    logic       in_acc;

    // escape decode
    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        res0    = '{data: i_text_byte, str_end: (i_text_byte == CHAR_NUL)};
        res1    = '{data: i_text_byte, str_end: (i_text_byte == CHAR_NUL)};
        res_cnt = 2'd0;
        case (r_mode)
            MODE_TEXT: begin
                if (i_text_byte == CHAR_BSL) begin
                    n_mode = MODE_ESC;
                end else begin
                    res_cnt = 2'd1;
                end
            end
            MODE_ESC: begin
                n_mode = MODE_TEXT;
                if (i_text_byte == CHAR_X) begin
                    n_mode = MODE_HEX1;
                end else if (i_text_byte == CHAR_R) begin
                    res0    = '{data: CHAR_CR, str_end: 1'b0};
                    res_cnt = 2'd1;
                end else if (i_text_byte == CHAR_N) begin
                    res0    = '{data: CHAR_LF, str_end: 1'b0};
                    res_cnt = 2'd1;
                end else if (i_text_byte inside {CHAR_SQ, CHAR_DQ, CHAR_BSL} ||
                             is_dec(i_text_byte) || i_text_byte == CHAR_NUL) begin
                    // literal escape, or terminator inside an escape
                    res_cnt = 2'd1;
                end else begin
                    // unknown escape: backslash then the byte itself
                    res0    = '{data: CHAR_BSL, str_end: 1'b0};
                    res_cnt = 2'd2;
                end
            end
            MODE_HEX1: begin
                if (is_hex(i_text_byte)) begin
                    n_held = i_text_byte;
                    n_mode = MODE_HEX2;
                end else begin
                    res_cnt = 2'd1;
                    n_mode  = MODE_TEXT;
                end
            end
            MODE_HEX2: begin
                if (is_hex(i_text_byte)) begin
                    res0    = '{data: {hex_val(r_held), hex_val(i_text_byte)}, str_end: 1'b0};
                    res_cnt = 2'd1;
                    n_mode  = MODE_TEXT;
                end else begin
                    // bad second digit: held digit, then byte as normal text
                    res0 = '{data: r_held, str_end: 1'b0};
                    if (i_text_byte == CHAR_BSL) begin
                        res_cnt = 2'd1;
                        n_mode  = MODE_ESC;
                    end else begin
                        res_cnt = 2'd2;
                        n_mode  = MODE_TEXT;
                    end
                end
            end
            default: begin
                n_mode = MODE_TEXT;
            end
        endcase
    end

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_pend_valid || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT;
            r_held <= CHAR_NUL;
        end else if (in_acc) begin
            r_mode <= n_mode;
            r_held <= n_held;
        end
    end

    // output register and pending second result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (r_pend_valid && out_free) begin
            r_out        <= r_pend;
            r_out_last   <= 1'b1;
            r_out_valid  <= 1'b1;
            r_pend_valid <= 1'b0;
        end else if (in_acc && res_cnt != 2'd0) begin
            r_out        <= res0;
            r_out_last   <= (res_cnt == 2'd1);
            r_out_valid  <= 1'b1;
            r_pend       <= res1;
            r_pend_valid <= (res_cnt == 2'd2);
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_decoded_byte = r_out.data;
    assign o_string_end   = r_out.str_end;
    assign o_last_of_run  = r_out_last;

endmodule

[verif/tb_backslash_escape_decoder.sv]
`timescale 1ns / 1ps
// Self-checking testbench for backslash_escape_decoder: directed escapes, then random
// escape sequences with random idling on both channels, scored against an inline predictor.
// Depends on bed_pkg and the decoder RTL.

module tb_backslash_escape_decoder
    import bed_pkg::*;
();

    localparam int RANDOM_ITEMS = 1950;
    localparam int TAIL_ITEMS   = 150;

    // one expected decoded beat
    typedef struct packed {
        logic [7:0] data;
        logic       str_end;
        logic       last;
    } t_decoded;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_decoded_byte;
    logic       o_string_end;
    logic       o_last_of_run;

    logic [7:0] text_q [$];      // text bytes waiting to be sent
    t_decoded   decoded_q [$];   // decoded beats still to come out
    t_decoded   run_q [$];       // beats caused by the byte being decoded

    // predictor state
    t_mode      dec_mode;
    logic [7:0] held_hex;

    bit in_beat_taken;
    bit fill_done;
    int text_total;
    int mismatches;
    int send_gap;
    int tx_idle_pct;
    int rx_gap;
    int rx_idle_pct;

    backslash_escape_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_decoded_byte (o_decoded_byte),
        .o_string_end   (o_string_end),
        .o_last_of_run  (o_last_of_run)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // nibble of a hex digit, bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9) begin
            return {1'b0, c[3:0]};
        end else if ((c >= CHAR_LA && c <= CHAR_LF_HX) || (c >= CHAR_UA && c <= CHAR_UF)) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic str_end);
        run_q.push_back('{data: b, str_end: str_end, last: 1'b0});
    endfunction

    // byte seen in normal text mode
    function automatic void decode_plain(input logic [7:0] b);
        if (b == CHAR_BSL) begin
            dec_mode = MODE_ESC;
        end else begin
            emit(b, b == CHAR_NUL);
            dec_mode = MODE_TEXT;
        end
    endfunction

    // advance the decoder by one text byte and queue what it emits
    function automatic void decode_text_byte(input logic [7:0] b);
        logic [4:0] nib_b;
        logic [4:0] nib_h;
        nib_b = nibble_of(b);
        nib_h = nibble_of(held_hex);
        case (dec_mode)
            MODE_ESC: begin
                dec_mode = MODE_TEXT;
                if (b == CHAR_X) begin
                    dec_mode = MODE_HEX1;
                end else if (b == CHAR_R) begin
                    emit(CHAR_CR, 1'b0);
                end else if (b == CHAR_N) begin
                    emit(CHAR_LF, 1'b0);
                end else if (b == CHAR_SQ || b == CHAR_DQ || b == CHAR_BSL ||
                             (b >= CHAR_0 && b <= CHAR_9)) begin
                    emit(b, 1'b0);
                end else if (b == CHAR_NUL) begin
                    emit(CHAR_NUL, 1'b1);
                end else begin
                    // unknown escape: backslash, then the byte as plain text
                    emit(CHAR_BSL, 1'b0);
                    decode_plain(b);
                end
            end
            MODE_HEX1: begin
                if (!nib_b[4]) begin
                    held_hex = b;
                    dec_mode = MODE_HEX2;
                end else begin
                    emit(b, b == CHAR_NUL);
                    dec_mode = MODE_TEXT;
                end
            end
            MODE_HEX2: begin
                if (!nib_b[4]) begin
                    emit({nib_h[3:0], nib_b[3:0]}, 1'b0);
                    dec_mode = MODE_TEXT;
                end else begin
                    // bad second digit: held digit literally, byte as plain text
                    emit(held_hex, 1'b0);
                    decode_plain(b);
                end
            end
            default: begin
                decode_plain(b);
            end
        endcase
        if (run_q.size() > 0) begin
            run_q[run_q.size() - 1].last = 1'b1;
        end
        foreach (run_q[k]) begin
            decoded_q.push_back(run_q[k]);
        end
        run_q.delete();
    endfunction

    function automatic bit tail_calm();
        return fill_done && text_q.size() < TAIL_ITEMS;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(3, 0))
            0: return 0;
            1: return 5;
            2: return 15;
            default: return 35;
        endcase
    endfunction

    function automatic logic [7:0] pick_hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(15, 0));
        if (v < 10) begin
            return CHAR_0 + v;
        end
        return ($urandom_range(1, 0) ? CHAR_LA : CHAR_UA) + v - 8'd10;
    endfunction

    function automatic void push_text(input logic [7:0] b);
        text_q.push_back(b);
        text_total++;
    endfunction

    // one random sequence: plain text, a well formed or malformed escape, a terminator or a random byte
    function automatic void queue_random_run();
        logic [7:0] b;
        case ($urandom_range(19, 0))
            0, 1, 2, 3, 4, 5: begin
                do begin
                    b = 8'($urandom_range(255, 1));
                end while (b == CHAR_BSL);
                push_text(b);
            end
            6, 7, 8: begin
                push_text(CHAR_BSL);
                case ($urandom_range(5, 0))
                    0: push_text(CHAR_R);
                    1: push_text(CHAR_N);
                    2: push_text(CHAR_SQ);
                    3: push_text(CHAR_DQ);
                    4: push_text(CHAR_BSL);
                    default: push_text(CHAR_0 + 8'($urandom_range(9, 0)));
                endcase
            end
            9, 10, 11: begin
                push_text(CHAR_BSL);
                push_text(CHAR_X);
                push_text(pick_hex_char());
                push_text(pick_hex_char());
            end
            12: begin
                push_text(CHAR_BSL);
                push_text(8'($urandom_range(255, 0)));
            end
            13: begin
                push_text(CHAR_BSL);
                push_text(CHAR_X);
                push_text(8'($urandom_range(255, 0)));
            end
            14: begin
                push_text(CHAR_BSL);
                push_text(CHAR_X);
                push_text(pick_hex_char());
                push_text(8'($urandom_range(255, 0)));
            end
            15: begin
                push_text(CHAR_NUL);
            end
            default: begin
                push_text(8'($urandom_range(255, 0)));
            end
        endcase
    endfunction

    // hold until every byte is sent and every decoded beat has come out
    task automatic wait_for_drain();
        @(posedge i_clk);
        while (text_q.size() != 0 || i_in_valid || decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // text byte driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_text_byte <= CHAR_NUL;
            send_gap    <= 0;
            tx_idle_pct <= pick_idle_pct();
        end else begin
            if ($urandom_range(63, 0) == 0) begin
                tx_idle_pct <= pick_idle_pct();
            end
            if (i_in_valid && !in_beat_taken) begin
                // stalled beat holds
            end else if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (text_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!tail_calm() && $urandom_range(99, 0) < tx_idle_pct) begin
                i_in_valid <= 1'b0;
                send_gap   <= $urandom_range(16, 0);
            end else begin
                i_in_valid  <= 1'b1;
                i_text_byte <= text_q.pop_front();
            end
        end
    end

    // output stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_gap      <= 0;
            rx_idle_pct <= pick_idle_pct();
        end else begin
            if ($urandom_range(63, 0) == 0) begin
                rx_idle_pct <= pick_idle_pct();
            end
            if (rx_gap > 0) begin
                i_out_stall <= 1'b1;
                rx_gap      <= rx_gap - 1;
            end else if (!tail_calm() && $urandom_range(99, 0) < rx_idle_pct) begin
                i_out_stall <= 1'b1;
                rx_gap      <= $urandom_range(16, 0);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // monitor: score output beats, predict from accepted input beats
    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            dec_mode      = MODE_TEXT;
            held_hex      = CHAR_NUL;
            in_beat_taken = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected output beat: decoded_byte %h", o_decoded_byte);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_decoded_byte !== want.data) begin
                        $error("decoded_byte: expected %h, got %h", want.data, o_decoded_byte);
                        mismatches++;
                    end
                    if (o_string_end !== want.str_end) begin
                        $error("string_end: expected %b, got %b", want.str_end, o_string_end);
                        mismatches++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last, o_last_of_run);
                        mismatches++;
                    end
                end
            end
            in_beat_taken = i_in_valid && !o_in_stall;
            if (in_beat_taken) begin
                decode_text_byte(i_text_byte);
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [7:0] opening [27];
        opening = '{CHAR_BSL, CHAR_X, "F", "f",          // highest hex value, mixed case
                    CHAR_BSL, CHAR_X, "0", "0",          // hex zero, not a terminator
                    CHAR_BSL, CHAR_R, CHAR_BSL, CHAR_N,
                    CHAR_BSL, "9",
                    CHAR_BSL, 8'hFF,                     // unknown escape, high byte
                    CHAR_BSL, CHAR_X, CHAR_BSL,          // bad first hex digit is a backslash
                    CHAR_BSL, CHAR_X, "a", CHAR_BSL, CHAR_N, // bad second digit starts escape
                    CHAR_BSL, CHAR_NUL,                  // terminator inside an escape
                    CHAR_NUL};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[k]) begin
            text_q.push_back(opening[k]);
        end
        wait_for_drain();

        text_total = 0;
        while (text_total < RANDOM_ITEMS / 2) begin
            queue_random_run();
        end
        // sender pauses until the decoder has fully drained
        wait_for_drain();
        while (text_total < RANDOM_ITEMS) begin
            queue_random_run();
        end
        fill_done = 1'b1;
        wait_for_drain();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(4_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

[backslash_escape_decoder.f]
rtl/bed_pkg.sv
rtl/backslash_escape_decoder.sv
verif/tb_backslash_escape_decoder.sv
